@@ design/sexpr_tokenizer_macros.svh @@
// ----------------------------------------------------------------------------
// S-expression tokenizer assertion macros
// Concurrent assertion wrappers that are left empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef SEXPR_TOKENIZER_MACROS_SVH
`define SEXPR_TOKENIZER_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define SXT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sexpr_tokenizer: same-cycle check failed");
// Antecedent implies consequent in the following cycle.
`define SXT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sexpr_tokenizer: next-cycle check failed");
`else
`define SXT_ASSERT_SAME(label, clk, rst, ante, cons)
`define SXT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ design/sxt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// S-expression tokenizer package
// Result beat type, result and error codes, and shared constants.
// ----------------------------------------------------------------------------
package sxt_pkg;

   // Depth of the result queue; it must hold at least two entries.
   localparam int unsigned RSP_FIFO_DEPTH = 4;

   localparam logic [7:0]  MAX_DEPTH      = 8'd255;
   localparam logic [7:0]  MAX_SYMBOL_LEN = 8'd255;
   localparam logic [62:0] INT_MAX        = '1;

   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   typedef enum logic [2:0] {
      KIND_OPEN  = 3'd0,
      KIND_CLOSE = 3'd1,
      KIND_INT   = 3'd2,
      KIND_SYM   = 3'd3,
      KIND_ERR   = 3'd4,
      KIND_END   = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE        = 3'd0,
      ERR_STRAY_CLOSE = 3'd1,
      ERR_UNKNOWN     = 3'd2,
      ERR_EOF_IN_LIST = 3'd3,
      ERR_TOO_DEEP    = 3'd4
   } err_type;

   typedef struct packed {
      kind_type    kind;
      logic [62:0] int_value;
      logic [31:0] sym_start;
      logic [7:0]  sym_len;
      err_type     err_code;
      logic [31:0] line;
      logic [31:0] column;
      logic [7:0]  depth;
      logic        last;
   } result_type;

   // Up to two result beats produced by one source byte.
   typedef struct packed {
      logic [1:0] cnt;
      result_type res0;
      result_type res1;
   } lex_wr_type;

   typedef struct packed {
      logic room;
      logic not_empty;
   } fifo_status_type;

endpackage : sxt_pkg
`default_nettype wire

@@ design/sxt_lexer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// S-expression tokenizer lexer step
// Holds the position counters and the token in progress, and turns one
// source beat into up to two result beats.
// ----------------------------------------------------------------------------
module sxt_lexer (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step_go,
   input  wire logic [7:0]         step_ch,
   input  wire logic               step_end,
   output sxt_pkg::lex_wr_type     lex_wr,
   output logic                    halted
);
   import sxt_pkg::*;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_INT,
      MODE_SYM,
      MODE_SEMI,
      MODE_COMMENT,
      MODE_HALT
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [31:0] line_ff, line_in;
   logic [31:0] col_ff, col_in;
   logic [31:0] pos_ff, pos_in;
   logic [7:0]  depth_ff, depth_in;
   logic [62:0] accum_ff, accum_in;
   logic [31:0] tok_start_ff, tok_start_in;
   logic [31:0] tok_line_ff, tok_line_in;
   logic [31:0] tok_col_ff, tok_col_in;
   logic [7:0]  tok_len_ff, tok_len_in;

   // Fresh-byte decode, used when no token is open or when the byte ends one.
   mode_type    fr_mode;
   logic        fr_emit;
   logic        fr_mark;
   logic [7:0]  fr_depth;
   result_type  fr_res;
   kind_type    fr_kind;
   err_type     fr_err;

   result_type  pend_res;
   result_type  fin_res;
   result_type  semi_res;
   logic        pending;
   logic [66:0] acc_wide;
   logic [62:0] acc_next;
   lex_wr_type  wr;

   function automatic logic is_numeral_f(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_blank_f(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_NL) || (c == CH_TAB) || (c == CH_CR);
   endfunction

   function automatic logic is_sym_f(input logic [7:0] c);
      logic r;
      r = is_numeral_f(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
          ((c >= 8'h61) && (c <= 8'h7A));
      // Punctuation allowed in symbols: ? ! . + - * / < = > : $ % ^ & _ ~ #
      case (c)
         8'h3F, 8'h21, 8'h2E, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3C, 8'h3D,
         8'h3E, 8'h3A, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h5F, 8'h7E, 8'h23: r = 1'b1;
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] sat_inc_f(input logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
   endfunction

   assign halted  = (mode_ff == MODE_HALT);
   assign pending = (mode_ff == MODE_INT) || (mode_ff == MODE_SYM);
   assign lex_wr  = wr;

   // Decimal accumulate with saturation: accum * 10 + digit.
   assign acc_wide = ({4'b0, accum_ff} << 3) + ({4'b0, accum_ff} << 1) + 67'(step_ch[3:0]);
   assign acc_next = (acc_wide > {4'b0, INT_MAX}) ? INT_MAX : acc_wide[62:0];

   always_comb begin
      fr_mode  = MODE_IDLE;
      fr_emit  = 1'b0;
      fr_mark  = 1'b0;
      fr_depth = depth_ff;
      fr_kind  = KIND_OPEN;
      fr_err   = ERR_NONE;
      if (is_blank_f(step_ch)) begin
         fr_mode = MODE_IDLE;
      end else if (step_ch == CH_SEMI) begin
         fr_mode = MODE_SEMI;
         fr_mark = 1'b1;
      end else if (is_numeral_f(step_ch)) begin
         fr_mode = MODE_INT;
         fr_mark = 1'b1;
      end else if (is_sym_f(step_ch)) begin
         fr_mode = MODE_SYM;
         fr_mark = 1'b1;
      end else if (step_ch == CH_LPAREN) begin
         fr_emit = 1'b1;
         if (depth_ff >= MAX_DEPTH) begin
            fr_mode = MODE_HALT;
            fr_kind = KIND_ERR;
            fr_err  = ERR_TOO_DEEP;
         end else begin
            fr_depth = depth_ff + 8'd1;
            fr_kind  = KIND_OPEN;
         end
      end else if (step_ch == CH_RPAREN) begin
         fr_emit = 1'b1;
         if (depth_ff == 8'd0) begin
            fr_mode = MODE_HALT;
            fr_kind = KIND_ERR;
            fr_err  = ERR_STRAY_CLOSE;
         end else begin
            fr_depth = depth_ff - 8'd1;
            fr_kind  = KIND_CLOSE;
         end
      end else begin
         fr_emit = 1'b1;
         fr_mode = MODE_HALT;
         fr_kind = KIND_ERR;
         fr_err  = ERR_UNKNOWN;
      end

      fr_res           = '0;
      fr_res.kind      = fr_kind;
      fr_res.err_code  = fr_err;
      fr_res.line      = line_ff;
      fr_res.column    = col_ff;
      fr_res.depth     = fr_depth;
   end

   always_comb begin
      pend_res           = '0;
      pend_res.kind      = (mode_ff == MODE_INT) ? KIND_INT : KIND_SYM;
      pend_res.int_value = (mode_ff == MODE_INT) ? accum_ff : 63'd0;
      pend_res.sym_start = (mode_ff == MODE_SYM) ? tok_start_ff : 32'd0;
      pend_res.sym_len   = (mode_ff == MODE_SYM) ? tok_len_ff : 8'd0;
      pend_res.err_code  = ERR_NONE;
      pend_res.line      = tok_line_ff;
      pend_res.column    = tok_col_ff;
      pend_res.depth     = depth_ff;

      fin_res          = '0;
      fin_res.kind     = (depth_ff != 8'd0) ? KIND_ERR : KIND_END;
      fin_res.err_code = (depth_ff != 8'd0) ? ERR_EOF_IN_LIST : ERR_NONE;
      fin_res.line     = line_ff;
      fin_res.column   = col_ff;
      fin_res.depth    = depth_ff;

      semi_res          = '0;
      semi_res.kind     = KIND_ERR;
      semi_res.err_code = ERR_UNKNOWN;
      semi_res.line     = tok_line_ff;
      semi_res.column   = tok_col_ff;
      semi_res.depth    = depth_ff;
   end

   always_comb begin
      mode_in      = mode_ff;
      line_in      = line_ff;
      col_in       = col_ff;
      pos_in       = pos_ff;
      depth_in     = depth_ff;
      accum_in     = accum_ff;
      tok_start_in = tok_start_ff;
      tok_line_in  = tok_line_ff;
      tok_col_in   = tok_col_ff;
      tok_len_in   = tok_len_ff;
      wr           = '0;

      if (step_go && (mode_ff != MODE_HALT)) begin
         if (step_end) begin
            mode_in = MODE_HALT;
            if (mode_ff == MODE_SEMI) begin
               wr.res0 = semi_res;
               wr.cnt  = 2'd1;
            end else if (pending) begin
               wr.res0 = pend_res;
               wr.res1 = fin_res;
               wr.cnt  = 2'd2;
            end else begin
               wr.res0 = fin_res;
               wr.cnt  = 2'd1;
            end
         end else begin
            // Every byte moves the position counters.
            if (step_ch == CH_NL) begin
               line_in = sat_inc_f(line_ff);
               col_in  = 32'd1;
            end else begin
               col_in  = sat_inc_f(col_ff);
            end
            pos_in = sat_inc_f(pos_ff);

            if ((mode_ff == MODE_COMMENT) || (mode_ff == MODE_SEMI)) begin
               if (mode_ff == MODE_COMMENT) begin
                  if (step_ch == CH_NL) begin
                     mode_in = MODE_IDLE;
                  end
               end else if (step_ch == CH_SEMI) begin
                  mode_in = MODE_COMMENT;
               end else begin
                  mode_in = MODE_HALT;
                  wr.res0 = semi_res;
                  wr.cnt  = 2'd1;
               end
            end else if ((mode_ff == MODE_INT) && is_numeral_f(step_ch)) begin
               accum_in = acc_next;
            end else if ((mode_ff == MODE_SYM) && is_sym_f(step_ch)) begin
               if (tok_len_ff < MAX_SYMBOL_LEN) begin
                  tok_len_in = tok_len_ff + 8'd1;
               end
            end else begin
               // Close any open token, then decode the byte afresh.
               if (pending) begin
                  wr.res0 = pend_res;
                  wr.res1 = fr_res;
                  wr.cnt  = fr_emit ? 2'd2 : 2'd1;
               end else if (fr_emit) begin
                  wr.res0 = fr_res;
                  wr.cnt  = 2'd1;
               end
               mode_in  = fr_mode;
               depth_in = fr_depth;
               if (fr_mark) begin
                  tok_line_in = line_ff;
                  tok_col_in  = col_ff;
               end
               if (fr_mode == MODE_INT) begin
                  accum_in = 63'(step_ch[3:0]);
               end
               if (fr_mode == MODE_SYM) begin
                  tok_start_in = pos_ff;
                  tok_len_in   = 8'd1;
               end
            end
         end
      end

      wr.res0.last = (wr.cnt == 2'd1);
      wr.res1.last = (wr.cnt == 2'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         line_ff      <= 32'd1;
         col_ff       <= 32'd1;
         pos_ff       <= 32'd0;
         depth_ff     <= 8'd0;
         accum_ff     <= 63'd0;
         tok_start_ff <= 32'd0;
         tok_line_ff  <= 32'd1;
         tok_col_ff   <= 32'd1;
         tok_len_ff   <= 8'd0;
      end else begin
         mode_ff      <= mode_in;
         line_ff      <= line_in;
         col_ff       <= col_in;
         pos_ff       <= pos_in;
         depth_ff     <= depth_in;
         accum_ff     <= accum_in;
         tok_start_ff <= tok_start_in;
         tok_line_ff  <= tok_line_in;
         tok_col_ff   <= tok_col_in;
         tok_len_ff   <= tok_len_in;
      end
   end

endmodule : sxt_lexer
`default_nettype wire

@@ design/sxt_rsp_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// S-expression tokenizer result queue
// Small register queue that takes up to two result beats per cycle and
// hands out one.
// ----------------------------------------------------------------------------
module sxt_rsp_fifo #(
   parameter int unsigned DEPTH = sxt_pkg::RSP_FIFO_DEPTH
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire sxt_pkg::lex_wr_type         wr,
   input  wire logic                        pop,
   output sxt_pkg::result_type              head,
   output sxt_pkg::fifo_status_type         stat,
   output logic [$clog2(DEPTH + 1) - 1:0]   level
);
   import sxt_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned LW = $clog2(DEPTH + 1);

   result_type      mem [DEPTH];
   logic [PW - 1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW - 1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW - 1:0] wr_ptr2;
   logic [LW - 1:0] level_ff, level_in;

   function automatic logic [PW - 1:0] ptr_next_f(input logic [PW - 1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign wr_ptr2        = ptr_next_f(wr_ptr_ff);
   assign head           = mem[rd_ptr_ff];
   assign level          = level_ff;
   assign stat.room      = (level_ff <= LW'(DEPTH - 2));
   assign stat.not_empty = (level_ff != '0);

   always_comb begin
      case (wr.cnt)
         2'd1:    wr_ptr_in = wr_ptr2;
         2'd2:    wr_ptr_in = ptr_next_f(wr_ptr2);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? ptr_next_f(rd_ptr_ff) : rd_ptr_ff;
      level_in  = level_ff + LW'(wr.cnt) - LW'(pop);
   end

   always_ff @(posedge clock) begin
      if (wr.cnt != 2'd0) begin
         mem[wr_ptr_ff] <= wr.res0;
      end
      if (wr.cnt == 2'd2) begin
         mem[wr_ptr2] <= wr.res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule : sxt_rsp_fifo
`default_nettype wire

@@ design/sexpr_tokenizer.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "sexpr_tokenizer_macros.svh"
// ----------------------------------------------------------------------------
// S-expression tokenizer
// Lexes a byte stream into list, integer, symbol, error and end tokens,
// each tagged with the line and column where it starts.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Beat content
//   req_     in         req_valid / req_stall  one source byte or end marker
//   rsp_     out        rsp_valid / rsp_stall  one token with its location
//
// One source beat is taken per cycle while req_stall is low. The lexer step works on
// the beat in the input register and writes its results into the queue at the next
// edge, so the first result is on rsp_ in the cycle after the step runs. A byte gives
// up to two results; rsp_ hands out one per cycle unless rsp_stall is high. The input
// register waits while the queue has under two free entries; req_stall is high meanwhile.
// Reset is synchronous and clears the counters, the token, the input beat and the queue.
// ----------------------------------------------------------------------------
module sexpr_tokenizer #(
   parameter int unsigned FIFO_DEPTH = sxt_pkg::RSP_FIFO_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_ch,
   input  wire logic        req_is_end,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_kind,
   output logic [62:0]      rsp_int_value,
   output logic [31:0]      rsp_sym_start,
   output logic [7:0]       rsp_sym_len,
   output logic [2:0]       rsp_err_code,
   output logic [31:0]      rsp_line,
   output logic [31:0]      rsp_column,
   output logic [7:0]       rsp_depth,
   output logic             rsp_last
);
   import sxt_pkg::*;

   localparam int unsigned LW = $clog2(FIFO_DEPTH + 1);

   // Input register: holds one accepted beat until the lexer step takes it.
   logic            in_vld_ff, in_vld_in;
   logic [7:0]      in_ch_ff;
   logic            in_end_ff;

   logic            req_take;
   logic            step_go;
   logic            rsp_take;
   logic            halted;
   lex_wr_type      lex_wr;
   result_type      head;
   fifo_status_type fifo_stat;
   logic [LW - 1:0] fifo_level;

   // The step runs only when both results of the byte are sure to fit.
   assign step_go   = in_vld_ff && fifo_stat.room;
   assign req_stall = in_vld_ff && !fifo_stat.room;
   assign req_take  = req_valid && !req_stall;
   assign in_vld_in = req_take || (in_vld_ff && !step_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   // The payload only loads on a taken beat, so it needs no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ch_ff  <= req_ch;
         in_end_ff <= req_is_end;
      end
   end

   sxt_lexer u_lexer (
      .clock    (clock),
      .reset    (reset),
      .step_go  (step_go),
      .step_ch  (in_ch_ff),
      .step_end (in_end_ff),
      .lex_wr   (lex_wr),
      .halted   (halted)
   );

   sxt_rsp_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .wr    (lex_wr),
      .pop   (rsp_take),
      .head  (head),
      .stat  (fifo_stat),
      .level (fifo_level)
   );

   // Result port: the head of the queue is presented until it is taken.
   assign rsp_valid     = fifo_stat.not_empty;
   assign rsp_take      = rsp_valid && !rsp_stall;
   assign rsp_kind      = head.kind;
   assign rsp_int_value = head.int_value;
   assign rsp_sym_start = head.sym_start;
   assign rsp_sym_len   = head.sym_len;
   assign rsp_err_code  = head.err_code;
   assign rsp_line      = head.line;
   assign rsp_column    = head.column;
   assign rsp_depth     = head.depth;
   assign rsp_last      = head.last;

   // The queue never holds more than its depth.
   `SXT_ASSERT_SAME(a_level_bound, clock, reset, 1'b1, fifo_level <= LW'(FIFO_DEPTH))
   // Once halted by an error or the end of text, the lexer writes nothing.
   `SXT_ASSERT_SAME(a_halt_quiet, clock, reset, halted, lex_wr.cnt == 2'd0)
   // An open-list result always reports a depth of at least one.
   `SXT_ASSERT_SAME(a_open_depth, clock, reset,
      (lex_wr.cnt != 2'd0) && (lex_wr.res0.kind == KIND_OPEN), lex_wr.res0.depth != 8'd0)
   // With the queue empty and nothing written, no result appears next cycle.
   `SXT_ASSERT_NEXT(a_no_phantom, clock, reset, !rsp_valid && (lex_wr.cnt == 2'd0), !rsp_valid)

endmodule : sexpr_tokenizer
`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S-expression tokenizer testbench
// Streams one long source text through the tokenizer, predicts every token
// with a behavioral lexer kept alongside the design, and compares each
// result beat field by field while the channels idle and stall at random at first.
// ----------------------------------------------------------------------------
module testbench;
   import sxt_pkg::*;

   // The lexer halts for good on its first error or end token, and reset is
   // applied only once. The whole run is therefore a single text: a short
   // scripted opening, a long stretch of random well-formed content, one
   // randomly chosen way of ending it, and a tail of beats that must be
   // ignored.
   localparam int RANDOM_BEATS = 950;
   localparam int TAIL_BEATS   = 16;
   localparam int DRAIN_CYCLES = 20;

   typedef enum logic [2:0] {
      LX_IDLE,
      LX_INT,
      LX_SYM,
      LX_SEMI,
      LX_COMMENT,
      LX_HALT
   } lex_mode_type;

   // Ways the text is brought to its end.
   typedef enum logic [2:0] {
      FIN_CLEAN,
      FIN_OPEN_LIST,
      FIN_STRAY_CLOSE,
      FIN_TOO_DEEP,
      FIN_BAD_CHAR,
      FIN_SEMI_BYTE,
      FIN_SEMI_END
   } finish_type;

   // One row of the scripted opening. Rows with typed set carry the single
   // token they must produce; the others are left to the predictor.
   typedef struct packed {
      logic [7:0] ch;
      logic       typed;
      result_type want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid  = 1'b0;
   logic        req_stall;
   logic [7:0]  req_ch     = 8'd0;
   logic        req_is_end = 1'b0;

   logic        rsp_valid;
   logic        rsp_stall  = 1'b0;
   logic [2:0]  rsp_kind;
   logic [62:0] rsp_int_value;
   logic [31:0] rsp_sym_start;
   logic [7:0]  rsp_sym_len;
   logic [2:0]  rsp_err_code;
   logic [31:0] rsp_line;
   logic [31:0] rsp_column;
   logic [7:0]  rsp_depth;
   logic        rsp_last;

   sexpr_tokenizer DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_ch        (req_ch),
      .req_is_end    (req_is_end),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_int_value (rsp_int_value),
      .rsp_sym_start (rsp_sym_start),
      .rsp_sym_len   (rsp_sym_len),
      .rsp_err_code  (rsp_err_code),
      .rsp_line      (rsp_line),
      .rsp_column    (rsp_column),
      .rsp_depth     (rsp_depth),
      .rsp_last      (rsp_last)
   );

   // 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Hard stop: a correct run ends long before five milliseconds, so this
   // timeout only trips when something has hung.
   initial begin
      #5_000_000;
      $display("testbench NOT OK");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Behavioral lexer. Its state mirrors the token in progress and the
   // position counters; one call handles one accepted source beat and leaves
   // the tokens it causes in step_out[0 .. step_n-1].
   // ------------------------------------------------------------------------
   logic [31:0]  lx_line, lx_col, lx_pos;
   logic [7:0]   lx_depth;
   lex_mode_type lx_mode;
   logic [62:0]  lx_accum;
   logic [31:0]  tok_pos, tok_line, tok_col;
   logic [7:0]   tok_len;
   result_type   step_out [0:1];
   int           step_n;

   result_type  tokens_due [$];
   logic        failed = 1'b0;

   function automatic void lex_reset();
      lx_line  = 32'd1;
      lx_col   = 32'd1;
      lx_pos   = 32'd0;
      lx_depth = 8'd0;
      lx_mode  = LX_IDLE;
      lx_accum = 63'd0;
      tok_pos  = 32'd0;
      tok_line = 32'd1;
      tok_col  = 32'd1;
      tok_len  = 8'd0;
      step_n   = 0;
   endfunction

   function automatic logic numeral_ch(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic blank_ch(logic [7:0] c);
      return c == CH_SPACE || c == CH_NL || c == CH_TAB || c == CH_CR;
   endfunction

   function automatic logic is_symch(logic [7:0] c);
      case (c)
         "?", "!", ".", "+", "-", "*", "/", "<", "=", ">", ":", "$", "%", "^",
         "&", "_", "~", "#": return 1'b1;
         default: return numeral_ch(c) || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
      endcase
   endfunction

   function automatic logic [31:0] bump32(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   // Fields that do not belong to a kind stay zero; depth is the depth after
   // the token.
   function automatic void put_token(kind_type k, logic [62:0] ival, logic [31:0] sstart,
                                     logic [7:0] slen, err_type ecode,
                                     logic [31:0] ln, logic [31:0] col);
      result_type t;
      t.kind      = k;
      t.int_value = ival;
      t.sym_start = sstart;
      t.sym_len   = slen;
      t.err_code  = ecode;
      t.line      = ln;
      t.column    = col;
      t.depth     = lx_depth;
      t.last      = 1'b0;
      step_out[step_n] = t;
      step_n++;
   endfunction

   function automatic void halt_error(err_type ecode, logic [31:0] ln, logic [31:0] col);
      put_token(KIND_ERR, 63'd0, 32'd0, 8'd0, ecode, ln, col);
      lx_mode = LX_HALT;
   endfunction

   // Hands out an integer or symbol that is still being read.
   function automatic void flush_token();
      if (lx_mode == LX_INT)
         put_token(KIND_INT, lx_accum, 32'd0, 8'd0, ERR_NONE, tok_line, tok_col);
      else if (lx_mode == LX_SYM)
         put_token(KIND_SYM, 63'd0, tok_pos, tok_len, ERR_NONE, tok_line, tok_col);
      lx_mode = LX_IDLE;
   endfunction

   // A byte seen between tokens.
   function automatic void lex_fresh(logic [7:0] c);
      if (!blank_ch(c)) begin
         if (c == CH_SEMI) begin
            lx_mode  = LX_SEMI;
            tok_line = lx_line;
            tok_col  = lx_col;
         end else if (numeral_ch(c)) begin
            lx_mode  = LX_INT;
            lx_accum = 63'(c - "0");
            tok_line = lx_line;
            tok_col  = lx_col;
         end else if (is_symch(c)) begin
            lx_mode  = LX_SYM;
            tok_pos  = lx_pos;
            tok_len  = 8'd1;
            tok_line = lx_line;
            tok_col  = lx_col;
         end else if (c == CH_LPAREN) begin
            if (lx_depth >= MAX_DEPTH) begin
               halt_error(ERR_TOO_DEEP, lx_line, lx_col);
            end else begin
               lx_depth++;
               put_token(KIND_OPEN, 63'd0, 32'd0, 8'd0, ERR_NONE, lx_line, lx_col);
            end
         end else if (c == CH_RPAREN) begin
            if (lx_depth == 8'd0) begin
               halt_error(ERR_STRAY_CLOSE, lx_line, lx_col);
            end else begin
               lx_depth--;
               put_token(KIND_CLOSE, 63'd0, 32'd0, 8'd0, ERR_NONE, lx_line, lx_col);
            end
         end else begin
            halt_error(ERR_UNKNOWN, lx_line, lx_col);
         end
      end
   endfunction

   function automatic void lex_beat(logic [7:0] c, logic is_end);
      logic [63:0] acc64;
      logic [63:0] dig;
      step_n = 0;
      if (lx_mode != LX_HALT) begin
         if (is_end) begin
            // A lone semicolon right before the end is an unknown character.
            if (lx_mode == LX_SEMI) begin
               halt_error(ERR_UNKNOWN, tok_line, tok_col);
            end else begin
               flush_token();
               if (lx_depth > 8'd0) begin
                  halt_error(ERR_EOF_IN_LIST, lx_line, lx_col);
               end else begin
                  put_token(KIND_END, 63'd0, 32'd0, 8'd0, ERR_NONE, lx_line, lx_col);
                  lx_mode = LX_HALT;
               end
            end
         end else begin
            case (lx_mode)
               LX_COMMENT: begin
                  if (c == CH_NL) lx_mode = LX_IDLE;
               end
               LX_SEMI: begin
                  if (c == CH_SEMI) lx_mode = LX_COMMENT;
                  else halt_error(ERR_UNKNOWN, tok_line, tok_col);
               end
               LX_INT: begin
                  if (numeral_ch(c)) begin
                     acc64 = {1'b0, lx_accum};
                     dig   = 64'(c) - 64'h30;
                     if (acc64 > (64'(INT_MAX) - dig) / 64'd10) lx_accum = INT_MAX;
                     else lx_accum = 63'(acc64 * 64'd10 + dig);
                  end else begin
                     flush_token();
                     lex_fresh(c);
                  end
               end
               LX_SYM: begin
                  if (is_symch(c)) begin
                     if (tok_len < MAX_SYMBOL_LEN) tok_len++;
                  end else begin
                     flush_token();
                     lex_fresh(c);
                  end
               end
               default: lex_fresh(c);
            endcase
            if (c == CH_NL) begin
               lx_line = bump32(lx_line);
               lx_col  = 32'd1;
            end else begin
               lx_col = bump32(lx_col);
            end
            lx_pos = bump32(lx_pos);
         end
         if (step_n > 0) step_out[step_n - 1].last = 1'b1;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Scoreboard. Both channels are looked at on the rising edge, where the
   // values seen are the ones that settled after the last falling edge. A
   // result beat never belongs to a source beat taken at the same edge, so
   // checking before predicting is safe.
   // ------------------------------------------------------------------------
   logic       beat_typed = 1'b0;
   result_type beat_want  = '0;

   function automatic void field_check(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failed = 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (tokens_due.size() == 0) begin
               $error("token beat with nothing expected: kind %0d", rsp_kind);
               failed = 1'b1;
            end else begin
               want = tokens_due.pop_front();
               field_check("kind",      64'(want.kind),      64'(rsp_kind));
               field_check("int_value", 64'(want.int_value), 64'(rsp_int_value));
               field_check("sym_start", 64'(want.sym_start), 64'(rsp_sym_start));
               field_check("sym_len",   64'(want.sym_len),   64'(rsp_sym_len));
               field_check("err_code",  64'(want.err_code),  64'(rsp_err_code));
               field_check("line",      64'(want.line),      64'(rsp_line));
               field_check("column",    64'(want.column),    64'(rsp_column));
               field_check("depth",     64'(want.depth),     64'(rsp_depth));
               field_check("last",      64'(want.last),      64'(rsp_last));
            end
         end
         if (req_valid && !req_stall) begin
            // The lexer always runs so its state follows the text; a typed
            // row overrides what it predicts.
            lex_beat(req_ch, req_is_end);
            if (beat_typed) begin
               tokens_due.push_back(beat_want);
            end else begin
               for (int i = 0; i < step_n; i++) tokens_due.push_back(step_out[i]);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Flow control. The run has three stretches: a receiver that stalls more often
   // than the sender idles, then the reverse, then both at full rate.
   // ------------------------------------------------------------------------
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int beats_sent    = 0;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   // Called and returning at a falling edge. While idle the payload wanders,
   // which is harmless with valid low; once raised, it holds until taken.
   task automatic send_beat(input logic [7:0] c, input logic is_end);
      if (beats_sent < 330) begin
         send_idle_pct = 27;
         rsp_stall_pct = 45;
      end else if (beats_sent < 660) begin
         send_idle_pct = 45;
         rsp_stall_pct = 27;
      end else begin
         send_idle_pct = 0;
         rsp_stall_pct = 0;
      end
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid  <= 1'b0;
         req_ch     <= 8'($urandom);
         req_is_end <= 1'($urandom);
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_ch     <= c;
      req_is_end <= is_end;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Source text generators.
   // ------------------------------------------------------------------------
   string sym_lead = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ?!.+-*_/<=>:$%^&~#";
   string sym_body = "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ?!.+-*_/<=>:$%^&~#";

   task automatic send_space();
      case ($urandom_range(0, 3))
         0: send_beat(CH_SPACE, 1'b0);
         1: send_beat(CH_NL, 1'b0);
         2: send_beat(CH_TAB, 1'b0);
         default: send_beat(CH_CR, 1'b0);
      endcase
   endtask

   task automatic send_integer(input int ndig);
      for (int i = 0; i < ndig; i++) send_beat(8'("0" + $urandom_range(0, 9)), 1'b0);
   endtask

   // The first byte must not be a digit, or the token would be an integer.
   task automatic send_symbol(input int len);
      send_beat(sym_lead[$urandom_range(0, sym_lead.len() - 1)], 1'b0);
      for (int i = 1; i < len; i++)
         send_beat(sym_body[$urandom_range(0, sym_body.len() - 1)], 1'b0);
   endtask

   // Comment bodies take any byte but newline, so every bit of the byte
   // field toggles here without halting the lexer.
   task automatic send_comment(input int len);
      logic [7:0] c;
      send_beat(CH_SEMI, 1'b0);
      send_beat(CH_SEMI, 1'b0);
      for (int i = 0; i < len; i++) begin
         do c = 8'($urandom); while (c == CH_NL);
         send_beat(c, 1'b0);
      end
      send_beat(CH_NL, 1'b0);
   endtask

   // Straight runs of parentheses keep the deep dives short.
   task automatic open_to_limit();
      while (lx_depth < MAX_DEPTH) send_beat(CH_LPAREN, 1'b0);
   endtask

   task automatic close_down_to(input logic [7:0] target);
      while (lx_depth > target) send_beat(CH_RPAREN, 1'b0);
   endtask

   // A token left unfinished right before the end must be flushed first.
   task automatic maybe_pending_token();
      case ($urandom_range(0, 2))
         0: send_integer($urandom_range(1, 3));
         1: send_symbol($urandom_range(1, 3));
         default: ;
      endcase
   endtask

   function automatic result_type typed_token(kind_type k, logic [62:0] ival,
                                              logic [31:0] ln, logic [31:0] col,
                                              logic [7:0] dep);
      result_type t;
      t        = '0;
      t.kind   = k;
      t.int_value = ival;
      t.err_code  = ERR_NONE;
      t.line   = ln;
      t.column = col;
      t.depth  = dep;
      t.last   = 1'b1;
      return t;
   endfunction

   function automatic script_row_type script_row(logic [7:0] c, logic typed,
                                                 result_type want);
      script_row_type r;
      r.ch    = c;
      r.typed = typed;
      r.want  = want;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------------
   initial begin
      script_row_type demo_script [$];
      finish_type     how;
      logic [7:0]     c;
      logic [7:0]     dive_from;
      int             base, dive_at, long_at, pick;
      logic           dove, went_long;

      // Scripted opening: an empty list, integer zero, the "12ab" split,
      // a comment holding the byte extremes, the odd symbol characters, and
      // bytes that end a token and open or close a list at once.
      demo_script.push_back(script_row(CH_LPAREN, 1'b1,
                            typed_token(KIND_OPEN, 63'd0, 32'd1, 32'd1, 8'd1)));
      demo_script.push_back(script_row(CH_RPAREN, 1'b1,
                            typed_token(KIND_CLOSE, 63'd0, 32'd1, 32'd2, 8'd0)));
      demo_script.push_back(script_row("0", 1'b0, '0));
      demo_script.push_back(script_row(CH_SPACE, 1'b1,
                            typed_token(KIND_INT, 63'd0, 32'd1, 32'd3, 8'd0)));
      demo_script.push_back(script_row("1", 1'b0, '0));
      demo_script.push_back(script_row("2", 1'b0, '0));
      demo_script.push_back(script_row("a", 1'b0, '0));
      demo_script.push_back(script_row("b", 1'b0, '0));
      demo_script.push_back(script_row(CH_TAB, 1'b0, '0));
      demo_script.push_back(script_row(CH_SEMI, 1'b0, '0));
      demo_script.push_back(script_row(CH_SEMI, 1'b0, '0));
      demo_script.push_back(script_row(8'h00, 1'b0, '0));
      demo_script.push_back(script_row(8'hFF, 1'b0, '0));
      demo_script.push_back(script_row(CH_NL, 1'b0, '0));
      demo_script.push_back(script_row(CH_LPAREN, 1'b0, '0));
      demo_script.push_back(script_row("~", 1'b0, '0));
      demo_script.push_back(script_row("#", 1'b0, '0));
      demo_script.push_back(script_row("_", 1'b0, '0));
      demo_script.push_back(script_row(CH_LPAREN, 1'b0, '0));
      demo_script.push_back(script_row("9", 1'b0, '0));
      demo_script.push_back(script_row(CH_RPAREN, 1'b0, '0));
      demo_script.push_back(script_row(CH_CR, 1'b0, '0));
      demo_script.push_back(script_row(CH_RPAREN, 1'b0, '0));
      demo_script.push_back(script_row(CH_NL, 1'b0, '0));

      lex_reset();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (demo_script[i]) begin
         beat_typed = demo_script[i].typed;
         beat_want  = demo_script[i].want;
         send_beat(demo_script[i].ch, 1'b0);
      end
      beat_typed = 1'b0;

      // Random content. Most of it is well-formed text; one dive to the
      // maximum depth and one symbol longer than the length limit start early
      // enough that both fit in the random beat budget.
      base      = beats_sent;
      dive_at   = $urandom_range(0, 150);
      long_at   = $urandom_range(0, 150);
      dove      = 1'b0;
      went_long = 1'b0;
      while (beats_sent - base < RANDOM_BEATS) begin
         if (!dove && beats_sent - base >= dive_at) begin
            dive_from = lx_depth;
            open_to_limit();
            close_down_to(dive_from);
            dove = 1'b1;
         end
         if (!went_long && beats_sent - base >= long_at) begin
            send_symbol($urandom_range(256, 260));
            send_space();
            went_long = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            send_beat((lx_depth < 8'd250) ? CH_LPAREN : CH_RPAREN, 1'b0);
         end else if (pick < 30) begin
            send_beat((lx_depth > 8'd0) ? CH_RPAREN : CH_LPAREN, 1'b0);
         end else if (pick < 50) begin
            // Now and then long enough to saturate.
            if ($urandom_range(0, 9) == 0) send_integer($urandom_range(18, 24));
            else send_integer($urandom_range(1, 4));
            if ($urandom_range(0, 3) != 0) send_space();
         end else if (pick < 72) begin
            send_symbol($urandom_range(1, 8));
            if ($urandom_range(0, 3) != 0) send_space();
         end else if (pick < 80) begin
            send_comment($urandom_range(0, 10));
         end else begin
            send_space();
         end
      end

      // Exactly one way of ending the text per run.
      how = finish_type'($urandom_range(0, 6));
      case (how)
         FIN_CLEAN: begin
            close_down_to(8'd0);
            maybe_pending_token();
            send_beat(8'($urandom), 1'b1);
         end
         FIN_OPEN_LIST: begin
            if (lx_depth == 8'd0) send_beat(CH_LPAREN, 1'b0);
            maybe_pending_token();
            send_beat(8'($urandom), 1'b1);
         end
         FIN_STRAY_CLOSE: begin
            close_down_to(8'd0);
            maybe_pending_token();
            send_beat(CH_RPAREN, 1'b0);
         end
         FIN_TOO_DEEP: begin
            open_to_limit();
            send_beat(CH_LPAREN, 1'b0);
         end
         FIN_BAD_CHAR: begin
            maybe_pending_token();
            do c = 8'($urandom);
            while (blank_ch(c) || is_symch(c) || c == CH_LPAREN || c == CH_RPAREN ||
                   c == CH_SEMI);
            send_beat(c, 1'b0);
         end
         FIN_SEMI_BYTE: begin
            send_beat(CH_SEMI, 1'b0);
            do c = 8'($urandom); while (c == CH_SEMI);
            send_beat(c, 1'b0);
         end
         default: begin
            send_beat(CH_SEMI, 1'b0);
            send_beat(8'($urandom), 1'b1);
         end
      endcase

      // The lexer is halted now; bytes and end markers alike must be
      // swallowed without a token.
      for (int i = 0; i < TAIL_BEATS; i++) send_beat(8'($urandom), 1'($urandom));
      req_valid <= 1'b0;

      while (tokens_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (!failed) $display("testbench OK");
      else $display("testbench NOT OK");
      $finish;
   end

endmodule
